### rtl/smpc_pkg.sv
// Shared types and constants for the serial menu PWM commander.
// No dependencies; included first by every other file.
`default_nettype none

package smpc_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned LedW     = 8;
  localparam int unsigned MotW     = 10;
  localparam int unsigned MotDutyW = MotW + 1;
  localparam int unsigned TgtW     = 3;
  localparam int unsigned LedNum   = 3;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgW     = 10;

  localparam logic [ByteW-1:0] AsciiZero  = 8'h30;
  localparam logic [ByteW-1:0] AsciiFive  = 8'h35;
  localparam logic [ByteW-1:0] AsciiMinus = 8'h2D;
  localparam logic [ByteW-1:0] AsciiPlus  = 8'h2B;
  localparam logic [ByteW-1:0] AsciiStop  = 8'h73;

  localparam logic [LedW-1:0] LedStepRst    = 8'd10;
  localparam logic [MotW-1:0] MotStepRst    = 10'd5;
  localparam logic [MotW-1:0] MotLimitRst   = 10'd255;

  typedef enum logic [TgtW-1:0] {
    TGT_RED   = 3'd0,
    TGT_GREEN = 3'd1,
    TGT_BLUE  = 3'd2,
    TGT_RMOT  = 3'd3,
    TGT_LMOT  = 3'd4,
    TGT_ADC   = 3'd5
  } tgt_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LED_STEP  = 2'd0,
    CFG_MOT_STEP  = 2'd1,
    CFG_MOT_LIMIT = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [ByteW-1:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic [LedW-1:0] red_compare;
    logic [LedW-1:0] green_compare;
    logic [LedW-1:0] blue_compare;
    logic [2:0]      led_output_on;
    logic [MotW-1:0] right_forward_cmp;
    logic [MotW-1:0] right_reverse_cmp;
    logic [MotW-1:0] left_forward_cmp;
    logic [MotW-1:0] left_reverse_cmp;
    logic            adc_streaming;
    logic            in_menu;
    logic [TgtW-1:0] selected_target;
  } out_t;

  typedef struct packed {
    logic inc;
    logic dec;
    logic clr;
  } mot_cmd_t;

endpackage

`default_nettype wire

### rtl/smpc_if.sv
// Valid/ready request channels for received bytes and for result snapshots.
// Depends on smpc_pkg for the payload types.
`default_nettype none

interface smpc_in_if import smpc_pkg::*; ();
  logic valid;
  logic ready;
  in_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface smpc_out_if import smpc_pkg::*; ();
  logic valid;
  logic ready;
  out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/smpc_motor.sv
// One motor channel: signed duty with clamped steps and forward/reverse compares.
// Depends on smpc_pkg for widths and the command struct.
`default_nettype none

module smpc_motor import smpc_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  mot_cmd_t        cmd_i,
  input  logic [MotW-1:0] step_i,
  input  logic [MotW-1:0] limit_i,
  output logic [MotW-1:0] fwd_o,
  output logic [MotW-1:0] rev_o
);

  logic signed [MotDutyW-1:0] duty_q, duty_d;
  logic        [MotW-1:0]     fwd_q, fwd_d;
  logic        [MotW-1:0]     rev_q, rev_d;

  logic signed [MotDutyW:0] duty_x, step_x, lim_x, nlim_x, up_x, dn_x, res_x;
  logic signed [MotDutyW-1:0] res_n;

  always_comb begin
    duty_x = {duty_q[MotDutyW-1], duty_q};
    step_x = $signed({2'b00, step_i});
    lim_x  = $signed({2'b00, limit_i});
    nlim_x = -lim_x;
    up_x   = duty_x + step_x;
    dn_x   = duty_x - step_x;
    if (cmd_i.inc) begin
      res_x = (up_x > lim_x) ? lim_x : up_x;
    end else begin
      res_x = (dn_x < nlim_x) ? nlim_x : dn_x;
    end
    res_n = res_x[MotDutyW-1:0];

    duty_d = duty_q;
    fwd_d  = fwd_q;
    rev_d  = rev_q;
    if (cmd_i.clr) begin
      duty_d = '0;
      fwd_d  = '0;
      rev_d  = '0;
    end else if (cmd_i.inc || cmd_i.dec) begin
      duty_d = res_n;
      if (res_n[MotDutyW-1]) begin
        rev_d = MotW'(-res_n);
      end else begin
        fwd_d = res_n[MotW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duty_q <= '0;
      fwd_q  <= '0;
      rev_q  <= '0;
    end else begin
      duty_q <= duty_d;
      fwd_q  <= fwd_d;
      rev_q  <= rev_d;
    end
  end

  assign fwd_o = fwd_q;
  assign rev_o = rev_q;

endmodule

`default_nettype wire

### rtl/serial_menu_pwm_commander_unit.sv
// A request accepted at an edge shows its result from that edge on.
// Throughput: one byte per cycle unless stalled; the state registers are the result.
// A new request is taken while the result is unclaimed only if it is taken in that cycle.
// Reset (rst_ni low, asynchronous): menu mode, target red, all duties, compares,
// enables and the streaming flag cleared; steps 10 and 5, motor limit 255.
// Depends on smpc_pkg, smpc_if and smpc_motor.
`default_nettype none

module serial_menu_pwm_commander_unit import smpc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  smpc_in_if.sink            in_ch,
  smpc_out_if.source         out_ch
);

  logic [LedW-1:0] led_step_q;
  logic [MotW-1:0] mot_step_q, mot_limit_q;

  logic            out_valid_q, out_valid_d;
  logic            menu_q, menu_d;
  tgt_e            target_q, target_d;
  logic            stream_q, stream_d;
  logic [LedW-1:0] led_duty_q [LedNum];
  logic [LedW-1:0] led_duty_d [LedNum];
  logic [LedW-1:0] led_cmp_q  [LedNum];
  logic [LedW-1:0] led_cmp_d  [LedNum];
  logic [LedNum-1:0] led_en_q, led_en_d, led_hit;

  logic            accept;
  logic [ByteW-1:0] rx;
  logic            is_minus, is_plus, is_stop;
  logic [LedW:0]   led_up;
  logic [LedW-1:0] led_up_sat, led_dn;
  mot_cmd_t        rmot_cmd, lmot_cmd;
  logic [MotW-1:0] rmot_fwd, rmot_rev, lmot_fwd, lmot_rev;

  assign in_ch.ready = !out_valid_q || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign rx          = in_ch.data.rx_byte;
  assign is_minus    = (rx == AsciiMinus);
  assign is_plus     = (rx == AsciiPlus);
  assign is_stop     = (rx == AsciiStop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      led_step_q  <= LedStepRst;
      mot_step_q  <= MotStepRst;
      mot_limit_q <= MotLimitRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_LED_STEP:  led_step_q  <= cfg_wdata_i[LedW-1:0];
        CFG_MOT_STEP:  mot_step_q  <= cfg_wdata_i[MotW-1:0];
        CFG_MOT_LIMIT: mot_limit_q <= cfg_wdata_i[MotW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    out_valid_d = accept ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_q);
    menu_d      = menu_q;
    target_d    = target_q;
    stream_d    = stream_q;
    if (accept) begin
      if (menu_q) begin
        if (rx >= AsciiZero && rx <= AsciiFive) begin
          target_d = tgt_e'(rx[TgtW-1:0]);
          menu_d   = 1'b0;
          if (rx == AsciiFive) begin
            stream_d = 1'b1;
          end
        end
      end else begin
        case (target_q)
          TGT_RED, TGT_GREEN, TGT_BLUE: begin
            if (!(is_minus || is_plus)) begin
              menu_d = 1'b1;
            end
          end
          TGT_RMOT, TGT_LMOT: begin
            if (!(is_minus || is_plus || is_stop)) begin
              menu_d = 1'b1;
            end
          end
          TGT_ADC: begin
            if (is_stop) begin
              stream_d = 1'b0;
              menu_d   = 1'b1;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    led_hit[0] = accept && !menu_q && (target_q == TGT_RED);
    led_hit[1] = accept && !menu_q && (target_q == TGT_GREEN);
    led_hit[2] = accept && !menu_q && (target_q == TGT_BLUE);
  end

  // one LED channel is selected at a time, so the adder is shared
  always_comb begin
    logic [LedW-1:0] duty_sel;
    duty_sel = led_duty_q[0];
    if (target_q == TGT_GREEN) begin
      duty_sel = led_duty_q[1];
    end else if (target_q == TGT_BLUE) begin
      duty_sel = led_duty_q[2];
    end
    led_up     = {1'b0, duty_sel} + {1'b0, led_step_q};
    led_up_sat = led_up[LedW] ? {LedW{1'b1}} : led_up[LedW-1:0];
    led_dn     = (duty_sel > led_step_q) ? (duty_sel - led_step_q) : '0;
  end

  always_comb begin
    led_en_d = led_en_q;
    for (int i = 0; i < LedNum; i++) begin
      led_duty_d[i] = led_duty_q[i];
      led_cmp_d[i]  = led_cmp_q[i];
      if (led_hit[i] && is_minus) begin
        led_duty_d[i] = led_up_sat;
        led_cmp_d[i]  = led_up_sat;
        led_en_d[i]   = 1'b1;
      end else if (led_hit[i] && is_plus) begin
        led_duty_d[i] = led_dn;
        if (led_dn == '0) begin
          led_en_d[i] = 1'b0;
        end else begin
          led_cmp_d[i] = led_dn;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      menu_q      <= 1'b1;
      target_q    <= TGT_RED;
      stream_q    <= 1'b0;
      led_en_q    <= '0;
      for (int i = 0; i < LedNum; i++) begin
        led_duty_q[i] <= '0;
        led_cmp_q[i]  <= '0;
      end
    end else begin
      out_valid_q <= out_valid_d;
      menu_q      <= menu_d;
      target_q    <= target_d;
      stream_q    <= stream_d;
      led_en_q    <= led_en_d;
      for (int i = 0; i < LedNum; i++) begin
        led_duty_q[i] <= led_duty_d[i];
        led_cmp_q[i]  <= led_cmp_d[i];
      end
    end
  end

  always_comb begin
    rmot_cmd.inc = accept && !menu_q && (target_q == TGT_RMOT) && is_plus;
    rmot_cmd.dec = accept && !menu_q && (target_q == TGT_RMOT) && is_minus;
    rmot_cmd.clr = accept && !menu_q && (target_q == TGT_RMOT) && is_stop;
    lmot_cmd.inc = accept && !menu_q && (target_q == TGT_LMOT) && is_plus;
    lmot_cmd.dec = accept && !menu_q && (target_q == TGT_LMOT) && is_minus;
    lmot_cmd.clr = accept && !menu_q && (target_q == TGT_LMOT) && is_stop;
  end

  smpc_motor u_rmot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (rmot_cmd),
    .step_i  (mot_step_q),
    .limit_i (mot_limit_q),
    .fwd_o   (rmot_fwd),
    .rev_o   (rmot_rev)
  );

  smpc_motor u_lmot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (lmot_cmd),
    .step_i  (mot_step_q),
    .limit_i (mot_limit_q),
    .fwd_o   (lmot_fwd),
    .rev_o   (lmot_rev)
  );

  assign out_ch.valid = out_valid_q;

  always_comb begin
    out_ch.data.red_compare       = led_cmp_q[0];
    out_ch.data.green_compare     = led_cmp_q[1];
    out_ch.data.blue_compare      = led_cmp_q[2];
    out_ch.data.led_output_on     = led_en_q;
    out_ch.data.right_forward_cmp = rmot_fwd;
    out_ch.data.right_reverse_cmp = rmot_rev;
    out_ch.data.left_forward_cmp  = lmot_fwd;
    out_ch.data.left_reverse_cmp  = lmot_rev;
    out_ch.data.adc_streaming     = stream_q;
    out_ch.data.in_menu           = menu_q;
    out_ch.data.selected_target   = target_q;
  end

  a_stream_tracks_adc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stream_q == (!menu_q && (target_q == TGT_ADC)))
    else $error("streaming flag out of step with menu state");

  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q)
    else $error("accepted request produced no result");

  a_state_holds_without_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> $stable(menu_q) && $stable(target_q) && $stable(led_en_q)
                && $stable(rmot_fwd) && $stable(lmot_rev))
    else $error("state changed without an accepted request");

endmodule

`default_nettype wire

### verif/tb_top.sv
// Self-checking bench for serial_menu_pwm_commander_unit: drives received bytes through
// the menu and command levels and compares each result snapshot with a scripted value or a local model.
// Depends on smpc_pkg, smpc_if and the unit itself.

module tb_top;
  import smpc_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned FieldNum   = 11;
  localparam int          LedMax     = (1 << LedW) - 1;

  localparam out_t SnapIdle = {8'd0, 8'd0, 8'd0, 3'b000, 10'd0, 10'd0, 10'd0, 10'd0,
                               1'b0, 1'b1, TGT_RED};
  localparam out_t SnapRedSel = {8'd0, 8'd0, 8'd0, 3'b000, 10'd0, 10'd0, 10'd0, 10'd0,
                                 1'b0, 1'b0, TGT_RED};
  localparam out_t SnapRedOn = {8'd10, 8'd0, 8'd0, 3'b001, 10'd0, 10'd0, 10'd0, 10'd0,
                                1'b0, 1'b0, TGT_RED};
  localparam out_t SnapRedOff = {8'd10, 8'd0, 8'd0, 3'b000, 10'd0, 10'd0, 10'd0, 10'd0,
                                 1'b0, 1'b0, TGT_RED};

  typedef struct {
    logic [ByteW-1:0] rx;
    bit               known;
    out_t             snap;
  } byte_note_t;

  typedef logic [31:0] field_vals_t [FieldNum];

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgW-1:0]  cfg_wdata_i;

  smpc_in_if  byte_ch ();
  smpc_out_if snap_ch ();

  serial_menu_pwm_commander_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_ch       (byte_ch),
    .out_ch      (snap_ch)
  );

  // local copy of the commander state and settings
  logic                      menu_q       = 1'b1;
  tgt_e                      tgt_q        = TGT_RED;
  logic                      stream_q     = 1'b0;
  logic [LedW-1:0]           led_duty_q [LedNum] = '{default: '0};
  logic [LedW-1:0]           led_cmp_q  [LedNum] = '{default: '0};
  logic [LedNum-1:0]         led_en_q     = '0;
  logic signed [MotDutyW-1:0] mot_duty_q [2] = '{default: '0};
  logic [MotW-1:0]           mot_cmp_q  [4] = '{default: '0};
  logic [LedW-1:0]           led_step_q   = LedStepRst;
  logic [MotW-1:0]           mot_step_q   = MotStepRst;
  logic [MotW-1:0]           mot_limit_q  = MotLimitRst;

  byte_note_t  byte_notes [$];
  out_t        snapshots_due [$];
  int unsigned bytes_sent     = 0;
  int unsigned snapshots_seen = 0;
  int unsigned mismatches     = 0;
  int unsigned cycles         = 0;
  int unsigned burst_left     = 0;
  bit          sender_gaps    = 1'b1;

  string field_names [FieldNum] = '{"red_compare", "green_compare", "blue_compare",
                                    "led_output_on", "right_forward_cmp",
                                    "right_reverse_cmp", "left_forward_cmp",
                                    "left_reverse_cmp", "adc_streaming", "in_menu",
                                    "selected_target"};

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic out_t take_rx_byte(input logic [ByteW-1:0] rx);
    int   ch;
    int   m;
    int   d;
    int   lim;
    int   v;
    out_t snap;
    if (menu_q) begin
      if (rx >= AsciiZero && rx <= AsciiFive) begin
        tgt_q  = tgt_e'(TgtW'(rx - AsciiZero));
        menu_q = 1'b0;
        if (tgt_q == TGT_ADC) stream_q = 1'b1;
      end
    end else begin
      case (tgt_q)
        TGT_RED, TGT_GREEN, TGT_BLUE: begin
          ch = int'(tgt_q);
          if (rx == AsciiMinus) begin
            v = int'(led_duty_q[ch]) + int'(led_step_q);
            if (v > LedMax) v = LedMax;
            led_duty_q[ch] = LedW'(v);
            led_cmp_q[ch]  = LedW'(v);
            led_en_q[ch]   = 1'b1;
          end else if (rx == AsciiPlus) begin
            v = int'(led_duty_q[ch]) - int'(led_step_q);
            if (v < 0) v = 0;
            led_duty_q[ch] = LedW'(v);
            if (v == 0) led_en_q[ch] = 1'b0;
            else led_cmp_q[ch] = LedW'(v);
          end else begin
            menu_q = 1'b1;
          end
        end
        TGT_RMOT, TGT_LMOT: begin
          m   = (tgt_q == TGT_LMOT) ? 1 : 0;
          d   = int'(mot_duty_q[m]);
          lim = int'(mot_limit_q);
          if (rx == AsciiPlus || rx == AsciiMinus) begin
            if (rx == AsciiPlus) begin
              d = d + int'(mot_step_q);
              if (d > lim) d = lim;
            end else begin
              d = d - int'(mot_step_q);
              if (d < -lim) d = -lim;
            end
            mot_duty_q[m] = MotDutyW'(d);
            if (d >= 0) mot_cmp_q[2*m] = MotW'(d);
            else mot_cmp_q[2*m+1] = MotW'(-d);
          end else if (rx == AsciiStop) begin
            mot_duty_q[m]    = '0;
            mot_cmp_q[2*m]   = '0;
            mot_cmp_q[2*m+1] = '0;
          end else begin
            menu_q = 1'b1;
          end
        end
        TGT_ADC: begin
          if (rx == AsciiStop) begin
            stream_q = 1'b0;
            menu_q   = 1'b1;
          end
        end
        default: ;
      endcase
    end
    snap.red_compare       = led_cmp_q[0];
    snap.green_compare     = led_cmp_q[1];
    snap.blue_compare      = led_cmp_q[2];
    snap.led_output_on     = led_en_q;
    snap.right_forward_cmp = mot_cmp_q[0];
    snap.right_reverse_cmp = mot_cmp_q[1];
    snap.left_forward_cmp  = mot_cmp_q[2];
    snap.left_reverse_cmp  = mot_cmp_q[3];
    snap.adc_streaming     = stream_q;
    snap.in_menu           = menu_q;
    snap.selected_target   = tgt_q;
    return snap;
  endfunction

  function automatic field_vals_t fields_of(input out_t s);
    return '{32'(s.red_compare), 32'(s.green_compare), 32'(s.blue_compare),
             32'(s.led_output_on), 32'(s.right_forward_cmp), 32'(s.right_reverse_cmp),
             32'(s.left_forward_cmp), 32'(s.left_reverse_cmp), 32'(s.adc_streaming),
             32'(s.in_menu), 32'(s.selected_target)};
  endfunction

  always @(posedge clk_i) begin : snapshot_check
    byte_note_t  note;
    out_t        want;
    field_vals_t w;
    field_vals_t g;
    if (snap_ch.valid && snap_ch.ready) begin
      if (snapshots_due.size() == 0) begin
        mismatches++;
        $display("%0t: result with no request pending, expected none actual %h",
                 $time, snap_ch.data);
      end else begin
        want = snapshots_due.pop_front();
        w    = fields_of(want);
        g    = fields_of(snap_ch.data);
        foreach (w[i]) begin
          if (w[i] !== g[i]) begin
            mismatches++;
            $display("%0t: %s expected %0d actual %0d", $time, field_names[i], w[i], g[i]);
          end
        end
        snapshots_seen++;
      end
    end
    if (byte_ch.valid && byte_ch.ready) begin
      note = byte_notes.pop_front();
      want = take_rx_byte(byte_ch.data.rx_byte);
      snapshots_due.push_back(note.known ? note.snap : want);
    end
  end

  initial begin : result_stalls
    int stall_left;
    stall_left = 0;
    snap_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        snap_ch.ready <= 1'b0;
      end else if (cycles[8:7] != 2'b00 && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 9);
        snap_ch.ready <= 1'b0;
      end else begin
        snap_ch.ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    while (cycles < CycleLimit) @(posedge clk_i) cycles++;
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic send_byte(input logic [ByteW-1:0] rx, input bit known = 1'b0,
                           input out_t snap = '0);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap        = sender_gaps ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
        byte_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    byte_notes.push_back('{rx, known, snap});
    bytes_sent++;
    byte_ch.valid        <= 1'b1;
    byte_ch.data.rx_byte <= rx;
    @(posedge clk_i);
    while (!byte_ch.ready) @(posedge clk_i);
    burst_left--;
  endtask

  // hold the sender until every request has its result
  task automatic settle();
    byte_ch.valid <= 1'b0;
    burst_left = 0;
    while (snapshots_seen != bytes_sent) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic load_settings(input logic [CfgW-1:0] led_w, input logic [MotW-1:0] mstep,
                               input logic [MotW-1:0] mlimit);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_LED_STEP;
    cfg_wdata_i <= led_w;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_MOT_STEP;
    cfg_wdata_i <= mstep;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_MOT_LIMIT;
    cfg_wdata_i <= mlimit;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    led_step_q  = led_w[LedW-1:0];
    mot_step_q  = mstep;
    mot_limit_q = mlimit;
  endtask

  // mostly well-formed select/command/leave sequences, with stray bytes between them
  task automatic run_phase(input int unsigned quota, input bit gaps);
    int unsigned      counted;
    int               len;
    int               pick;
    logic [ByteW-1:0] digit;
    logic [ByteW-1:0] b;
    sender_gaps = gaps;
    counted     = 0;
    while (counted < quota) begin
      if ($urandom_range(0, 7) == 0) begin
        send_byte(ByteW'($urandom));
      end else begin
        digit = AsciiZero + ByteW'($urandom_range(0, 5));
        send_byte(digit);
        counted++;
        if (digit == AsciiFive) begin
          repeat ($urandom_range(0, 3)) begin
            b = ByteW'($urandom);
            if (b == AsciiStop) b = AsciiMinus;
            send_byte(b);
          end
          if ($urandom_range(0, 9) != 0) begin
            send_byte(AsciiStop);
            counted++;
          end
        end else begin
          len = $urandom_range(1, 14);
          repeat (len) begin
            pick = $urandom_range(0, 9);
            if (pick < 4) b = AsciiMinus;
            else if (pick < 8) b = AsciiPlus;
            else if (pick == 8) b = (digit > AsciiZero + 8'd2) ? AsciiStop : AsciiMinus;
            else b = ByteW'($urandom);
            send_byte(b);
            counted++;
          end
          if ($urandom_range(0, 9) != 0) begin
            do b = ByteW'($urandom);
            while (b == AsciiPlus || b == AsciiMinus || b == AsciiStop);
            send_byte(b);
            counted++;
          end
        end
      end
    end
  endtask

  initial begin : stimulus
    byte_note_t script [$];
    script.push_back('{8'h00, 1'b1, SnapIdle});
    script.push_back('{8'hFF, 1'b1, SnapIdle});
    script.push_back('{AsciiZero - 8'd1, 1'b1, SnapIdle});
    script.push_back('{AsciiFive + 8'd1, 1'b1, SnapIdle});
    script.push_back('{AsciiZero, 1'b1, SnapRedSel});
    script.push_back('{AsciiPlus, 1'b1, SnapRedSel});
    script.push_back('{AsciiMinus, 1'b1, SnapRedOn});
    script.push_back('{AsciiPlus, 1'b1, SnapRedOff});
    script.push_back('{AsciiStop, 1'b0, '0});
    script.push_back('{AsciiZero + 8'd1, 1'b0, '0});
    script.push_back('{AsciiMinus, 1'b0, '0});
    script.push_back('{8'h80, 1'b0, '0});
    script.push_back('{AsciiZero + 8'd2, 1'b0, '0});
    script.push_back('{AsciiMinus, 1'b0, '0});
    script.push_back('{AsciiMinus, 1'b0, '0});
    script.push_back('{AsciiStop, 1'b0, '0});
    script.push_back('{AsciiZero + 8'd3, 1'b0, '0});
    script.push_back('{AsciiMinus, 1'b0, '0});
    script.push_back('{AsciiPlus, 1'b0, '0});
    script.push_back('{AsciiPlus, 1'b0, '0});
    script.push_back('{AsciiStop, 1'b0, '0});
    script.push_back('{8'h00, 1'b0, '0});
    script.push_back('{AsciiZero + 8'd4, 1'b0, '0});
    script.push_back('{AsciiPlus, 1'b0, '0});
    script.push_back('{AsciiZero, 1'b0, '0});
    script.push_back('{AsciiFive, 1'b0, '0});
    script.push_back('{AsciiPlus, 1'b0, '0});
    script.push_back('{AsciiStop, 1'b0, '0});

    rst_ni               <= 1'b0;
    cfg_we_i             <= 1'b0;
    cfg_idx_i            <= CFG_LED_STEP;
    cfg_wdata_i          <= '0;
    byte_ch.valid        <= 1'b0;
    byte_ch.data.rx_byte <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (script[i]) send_byte(script[i].rx, script[i].known, script[i].snap);

    settle();
    load_settings({2'($urandom), 8'hFF}, 10'h3FF, 10'h3FF);
    run_phase(80, 1'b1);
    settle();
    load_settings(CfgW'($urandom), MotW'($urandom), MotW'($urandom_range(0, 20)));
    run_phase(70, 1'b0);
    settle();
    load_settings('0, '0, '0);
    run_phase(50, 1'b1);
    settle();
    load_settings(CfgW'($urandom_range(1, 40)), MotW'($urandom_range(1, 64)),
                  MotW'($urandom));
    run_phase(100, 1'b1);
    settle();
    load_settings({2'($urandom), LedStepRst}, MotStepRst, MotLimitRst);
    run_phase(80, 1'b0);
    settle();

    if (mismatches == 0 && snapshots_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
